### sv/pcr_pkg.sv
`timescale 1ns / 1ps
// pcr_pkg: shared types, codes and helper functions of the control responder
// no dependencies; imported by the front, back, csr and top-level modules
package pcr_pkg;

   localparam int PCR_REQ_DEPTH   = 2;
   localparam int PCR_RSP_DEPTH   = 2;
   localparam int PCR_CRC_STAGES  = 4;
   localparam int PCR_ADDR_WIDTH  = 5;
   localparam int PCR_REG_IDX_W   = PCR_ADDR_WIDTH - 2;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [7:0] CMD_SET_TID   = 8'h01;
   localparam logic [7:0] CMD_GET_TID   = 8'h02;
   localparam logic [7:0] CMD_GET_VER   = 8'h03;
   localparam logic [7:0] CMD_GET_TYPES = 8'h04;
   localparam logic [7:0] CMD_GET_CMDS  = 8'h05;

   localparam logic [7:0] TID_UNASSIGNED = 8'h00;
   localparam logic [7:0] TID_RESERVED   = 8'hFF;
   localparam logic [7:0] XFER_FIRST     = 8'h01;

   localparam logic [7:0] TYPE_BASE     = 8'h00;
   localparam logic [7:0] TYPE_PLATFORM = 8'h02;
   localparam logic [7:0] TYPE_FRU      = 8'h04;
   localparam logic [7:0] TYPE_FW       = 8'h05;
   localparam logic [7:0] TYPE_RDE      = 8'h06;

   localparam logic [7:0] TYPES_BITMAP = 8'h75;

   localparam logic [63:0] CMDS_BASE_LO     = 64'h0000_0000_0000_003E;
   localparam logic [63:0] CMDS_PLATFORM_LO = 64'h0000_0003_002F_3C38;
   localparam logic [31:0] CMDS_PLATFORM_HI = 32'h000B_0000;
   localparam logic [63:0] CMDS_FRU_LO      = 64'h0000_0000_0000_0006;
   localparam logic [63:0] CMDS_FW_LO       = 64'h0000_0000_3CFB_0006;
   localparam logic [63:0] CMDS_RDE_LO      = 64'h0003_0000_007F_1FFE;

   typedef enum logic [PCR_REG_IDX_W-1:0] {
      REG_VERSION_TYPE0 = 3'd0,
      REG_VERSION_TYPE2 = 3'd1,
      REG_VERSION_TYPE4 = 3'd2,
      REG_VERSION_TYPE5 = 3'd3,
      REG_VERSION_TYPE6 = 3'd4
   } reg_idx_type;

   typedef enum logic [2:0] {
      OP_SET_TID,
      OP_GET_TID,
      OP_GET_VER,
      OP_GET_TYPES,
      OP_GET_CMDS,
      OP_UNSUP
   } op_type;

   typedef enum logic [2:0] {
      CC_OK           = 3'd0,
      CC_UNSUPPORTED  = 3'd1,
      CC_INVALID_DATA = 3'd2,
      CC_BAD_XFER     = 3'd3,
      CC_BAD_TYPE     = 3'd4,
      CC_BAD_VERSION  = 3'd5
   } cc_type;

   typedef enum logic [2:0] {
      BM_NONE,
      BM_BASE,
      BM_PLATFORM,
      BM_FRU,
      BM_FW,
      BM_RDE
   } bm_type;

   typedef struct packed {
      logic [31:0] version_type0;
      logic [31:0] version_type2;
      logic [31:0] version_type4;
      logic [31:0] version_type5;
      logic [31:0] version_type6;
   } cfg_type;

   // classified request between front and back
   typedef struct packed {
      op_type      op;
      cc_type      cc;
      logic [7:0]  tid;
      logic [31:0] version;
      bm_type      bm;
   } item_type;

   typedef struct packed {
      op_type      op;
      cc_type      cc;
      logic [7:0]  tid_out;
      logic        tid_changed;
      logic [31:0] version;
      logic [31:0] crc;
      bm_type      bm;
   } stage_type;

   typedef struct packed {
      cc_type      completion_code;
      logic [7:0]  tid_out;
      logic        tid_changed;
      logic [31:0] version_out;
      logic [31:0] version_crc;
      logic [7:0]  type_bitmap;
      logic [63:0] cmd_bits_low;
      logic [31:0] cmd_bits_high;
   } rsp_type;

   // one byte of reflected crc-32
   function automatic logic [31:0] pcr_crc_byte(input logic [31:0] crc,
                                                input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'h0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [95:0] pcr_cmd_bits(input bm_type bm);
      logic [95:0] bits;
      case (bm)
         BM_BASE:     bits = {32'h0, CMDS_BASE_LO};
         BM_PLATFORM: bits = {CMDS_PLATFORM_HI, CMDS_PLATFORM_LO};
         BM_FRU:      bits = {32'h0, CMDS_FRU_LO};
         BM_FW:       bits = {32'h0, CMDS_FW_LO};
         BM_RDE:      bits = {32'h0, CMDS_RDE_LO};
         default:     bits = '0;
      endcase
      return bits;
   endfunction

endpackage

### sv/pcr_fifo.sv
`timescale 1ns / 1ps
// pcr_fifo: small register-based queue with push/pop and full/empty flags
// no dependencies
module pcr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### sv/pcr_csr.sv
`timescale 1ns / 1ps
// pcr_csr: apb-style register file holding the per-type version words
// depends on pcr_pkg
module pcr_csr import pcr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PCR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[PCR_ADDR_WIDTH-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (idx)
         REG_VERSION_TYPE0: begin
            prdata = cfg_ff.version_type0;
            if (wr_en) cfg_in.version_type0 = pwdata;
         end
         REG_VERSION_TYPE2: begin
            prdata = cfg_ff.version_type2;
            if (wr_en) cfg_in.version_type2 = pwdata;
         end
         REG_VERSION_TYPE4: begin
            prdata = cfg_ff.version_type4;
            if (wr_en) cfg_in.version_type4 = pwdata;
         end
         REG_VERSION_TYPE5: begin
            prdata = cfg_ff.version_type5;
            if (wr_en) cfg_in.version_type5 = pwdata;
         end
         REG_VERSION_TYPE6: begin
            prdata = cfg_ff.version_type6;
            if (wr_en) cfg_in.version_type6 = pwdata;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/pcr_front.sv
`timescale 1ns / 1ps
// pcr_front: accepts requests, decodes the command and resolves type, version
// and completion code; depends on pcr_pkg
module pcr_front import pcr_pkg::*; (
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_cmd,
   input  logic [7:0]  req_tid,
   input  logic [7:0]  req_transfer_op,
   input  logic [7:0]  req_pldm_type,
   input  logic [31:0] req_version,
   input  cfg_type     cfg,
   output logic        item_push,
   output item_type    item,
   input  logic        item_full
);

   logic        known;
   logic [31:0] type_ver;
   bm_type      type_bm;

   assign full      = item_full;
   assign item_push = push && !item_full;

   // version lookup, unknown types fall back to type 0
   always_comb begin
      known    = 1'b1;
      type_ver = cfg.version_type0;
      type_bm  = BM_BASE;
      case (req_pldm_type)
         TYPE_BASE: begin
            type_ver = cfg.version_type0;
            type_bm  = BM_BASE;
         end
         TYPE_PLATFORM: begin
            type_ver = cfg.version_type2;
            type_bm  = BM_PLATFORM;
         end
         TYPE_FRU: begin
            type_ver = cfg.version_type4;
            type_bm  = BM_FRU;
         end
         TYPE_FW: begin
            type_ver = cfg.version_type5;
            type_bm  = BM_FW;
         end
         TYPE_RDE: begin
            type_ver = cfg.version_type6;
            type_bm  = BM_RDE;
         end
         default: begin
            known    = 1'b0;
            type_ver = cfg.version_type0;
            type_bm  = BM_NONE;
         end
      endcase
   end

   always_comb begin
      item.op      = OP_UNSUP;
      item.cc      = CC_OK;
      item.tid     = req_tid;
      item.version = '0;
      item.bm      = BM_NONE;
      case (req_cmd)
         CMD_SET_TID: begin
            item.op = OP_SET_TID;
            if (req_tid == TID_UNASSIGNED || req_tid == TID_RESERVED) begin
               item.cc = CC_INVALID_DATA;
            end
         end
         CMD_GET_TID: begin
            item.op = OP_GET_TID;
         end
         CMD_GET_VER: begin
            item.op      = OP_GET_VER;
            item.version = type_ver;
            if (!known) begin
               item.cc = CC_BAD_TYPE;
            end else if (req_transfer_op != XFER_FIRST) begin
               item.cc = CC_BAD_XFER;
            end
         end
         CMD_GET_TYPES: begin
            item.op = OP_GET_TYPES;
         end
         CMD_GET_CMDS: begin
            item.op = OP_GET_CMDS;
            if (!known) begin
               item.cc = CC_BAD_TYPE;
            end else if (req_version != type_ver) begin
               item.cc = CC_BAD_VERSION;
            end else begin
               item.bm = type_bm;
            end
         end
         default: begin
            item.op = OP_UNSUP;
            item.cc = CC_UNSUPPORTED;
         end
      endcase
   end

endmodule

### sv/pcr_back.sv
`timescale 1ns / 1ps
// pcr_back: executes classified items, keeps the terminus id and runs the
// byte-per-stage version checksum pipeline; depends on pcr_pkg
module pcr_back import pcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  item_type item,
   input  logic     item_empty,
   output logic     item_pop,
   output logic     rsp_push,
   output rsp_type  rsp,
   input  logic     rsp_full
);

   localparam int LAST = PCR_CRC_STAGES - 1;

   stage_type  stg_ff     [PCR_CRC_STAGES];
   stage_type  stg_in     [PCR_CRC_STAGES];
   logic       stg_vld_ff [PCR_CRC_STAGES];
   logic       stg_vld_in [PCR_CRC_STAGES];
   logic [7:0] tid_ff, tid_in;
   logic       adv;
   logic [95:0] cmd_bits;

   // the whole pipeline holds while the last stage cannot leave
   assign adv      = !(stg_vld_ff[LAST] && rsp_full);
   assign item_pop = adv && !item_empty;
   assign rsp_push = adv && stg_vld_ff[LAST];

   always_comb begin
      tid_in = tid_ff;

      stg_vld_in[0]         = !item_empty;
      stg_in[0].op          = item.op;
      stg_in[0].cc          = item.cc;
      stg_in[0].tid_out     = (item.op == OP_GET_TID) ? tid_ff : '0;
      stg_in[0].tid_changed = (item.op == OP_SET_TID) && (item.cc == CC_OK);
      stg_in[0].version     = item.version;
      stg_in[0].crc         = pcr_crc_byte(CRC_INIT, item.version[7:0]);
      stg_in[0].bm          = item.bm;
      if (item_pop && stg_in[0].tid_changed) begin
         tid_in = item.tid;
      end

      for (int k = 1; k < PCR_CRC_STAGES; k++) begin
         stg_vld_in[k] = stg_vld_ff[k-1];
         stg_in[k]     = stg_ff[k-1];
         stg_in[k].crc = pcr_crc_byte(stg_ff[k-1].crc, stg_ff[k-1].version[8*k +: 8]);
      end
   end

   always_comb begin
      cmd_bits            = pcr_cmd_bits(stg_ff[LAST].bm);
      rsp.completion_code = stg_ff[LAST].cc;
      rsp.tid_out         = stg_ff[LAST].tid_out;
      rsp.tid_changed     = stg_ff[LAST].tid_changed;
      rsp.version_out     = stg_ff[LAST].version;
      rsp.version_crc     = (stg_ff[LAST].op == OP_GET_VER) ? ~stg_ff[LAST].crc : '0;
      rsp.type_bitmap     = (stg_ff[LAST].op == OP_GET_TYPES) ? TYPES_BITMAP : '0;
      rsp.cmd_bits_low    = cmd_bits[63:0];
      rsp.cmd_bits_high   = cmd_bits[95:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tid_ff <= TID_UNASSIGNED;
         for (int k = 0; k < PCR_CRC_STAGES; k++) begin
            stg_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         tid_ff <= tid_in;
         for (int k = 0; k < PCR_CRC_STAGES; k++) begin
            stg_vld_ff[k] <= stg_vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < PCR_CRC_STAGES; k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

endmodule

### sv/pldm_control_responder.sv
`timescale 1ns / 1ps
// pldm_control_responder: top level of the control and discovery responder
// depends on pcr_pkg, pcr_csr, pcr_front, pcr_fifo and pcr_back
//
// Takes one request per cycle while full is low and returns one response per
// request, in order. The front decodes each request in the cycle it is pushed
// and places it in a short request queue; the back pops it into a four-stage
// pipeline that updates or reads the terminus id in its first stage and folds
// one version byte into the crc-32 per stage, then writes the response into
// the output queue. A response passes through the request queue, the four
// checksum stages and the output queue, and the pipeline holds as a whole
// while the output queue is full. Throughput is one item per cycle as long as
// responses are popped. The user writes the version registers through the apb
// port only while no request is in flight; the block does not enforce this.
module pldm_control_responder import pcr_pkg::*; #(
   parameter int REQ_QUEUE_DEPTH = PCR_REQ_DEPTH,
   parameter int RSP_QUEUE_DEPTH = PCR_RSP_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PCR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                req_cmd,
   input  logic [7:0]                req_tid,
   input  logic [7:0]                req_transfer_op,
   input  logic [7:0]                req_pldm_type,
   input  logic [31:0]               req_version,
   output logic                      empty,
   input  logic                      pop,
   output logic [2:0]                rsp_completion_code,
   output logic [7:0]                rsp_tid_out,
   output logic                      rsp_tid_changed,
   output logic [31:0]               rsp_version_out,
   output logic [31:0]               rsp_version_crc,
   output logic [7:0]                rsp_type_bitmap,
   output logic [63:0]               rsp_cmd_bits_low,
   output logic [31:0]               rsp_cmd_bits_high
);

   cfg_type  cfg;
   item_type item_wr, item_rd;
   logic     item_push, item_full, item_pop, item_empty;
   rsp_type  rsp_wr, rsp_rd;
   logic     rsp_push, rsp_full;
   logic [$bits(item_type)-1:0] item_rd_bits;
   logic [$bits(rsp_type)-1:0]  rsp_rd_bits;

   pcr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcr_front u_front (
      .push            (push),
      .full            (full),
      .req_cmd         (req_cmd),
      .req_tid         (req_tid),
      .req_transfer_op (req_transfer_op),
      .req_pldm_type   (req_pldm_type),
      .req_version     (req_version),
      .cfg             (cfg),
      .item_push       (item_push),
      .item            (item_wr),
      .item_full       (item_full)
   );

   pcr_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (REQ_QUEUE_DEPTH)
   ) u_req_queue (
      .clock (clock),
      .reset (reset),
      .push  (item_push),
      .din   (item_wr),
      .full  (item_full),
      .pop   (item_pop),
      .dout  (item_rd_bits),
      .empty (item_empty)
   );

   assign item_rd = item_type'(item_rd_bits);

   pcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item_rd),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .rsp_push   (rsp_push),
      .rsp        (rsp_wr),
      .rsp_full   (rsp_full)
   );

   pcr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_rd_bits),
      .empty (empty)
   );

   assign rsp_rd              = rsp_type'(rsp_rd_bits);
   assign rsp_completion_code = rsp_rd.completion_code;
   assign rsp_tid_out         = rsp_rd.tid_out;
   assign rsp_tid_changed     = rsp_rd.tid_changed;
   assign rsp_version_out     = rsp_rd.version_out;
   assign rsp_version_crc     = rsp_rd.version_crc;
   assign rsp_type_bitmap     = rsp_rd.type_bitmap;
   assign rsp_cmd_bits_low    = rsp_rd.cmd_bits_low;
   assign rsp_cmd_bits_high   = rsp_rd.cmd_bits_high;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for pldm_control_responder, apb version registers plus
// queue-style request and response channels; depends on pcr_pkg and the rtl only
module tb;
   import pcr_pkg::*;

   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          PHASE_ITEMS    = 420;
   localparam logic [7:0]  CMD_NONE       = 8'h00;
   localparam logic [7:0]  CMD_LAST       = 8'hFF;

   typedef struct {
      logic [7:0]  cmd;
      logic [7:0]  tid;
      logic [7:0]  xfer;
      logic [7:0]  ptype;
      logic [31:0] version;
   } pldm_request_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [PCR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;
   logic                      push = 1'b0;
   logic                      full;
   logic [7:0]                req_cmd = '0;
   logic [7:0]                req_tid = '0;
   logic [7:0]                req_transfer_op = '0;
   logic [7:0]                req_pldm_type = '0;
   logic [31:0]               req_version = '0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [2:0]                rsp_completion_code;
   logic [7:0]                rsp_tid_out;
   logic                      rsp_tid_changed;
   logic [31:0]               rsp_version_out;
   logic [31:0]               rsp_version_crc;
   logic [7:0]                rsp_type_bitmap;
   logic [63:0]               rsp_cmd_bits_low;
   logic [31:0]               rsp_cmd_bits_high;

   // bench copy of the block state and registers
   logic [31:0] version_regs [5];
   logic [7:0]  stored_tid;
   rsp_type     expected_rsps [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int fail_count = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_settings = 0;
   int op_count [6];

   pldm_control_responder u_dut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .push(push), .full(full),
      .req_cmd(req_cmd), .req_tid(req_tid), .req_transfer_op(req_transfer_op),
      .req_pldm_type(req_pldm_type), .req_version(req_version),
      .empty(empty), .pop(pop),
      .rsp_completion_code(rsp_completion_code), .rsp_tid_out(rsp_tid_out),
      .rsp_tid_changed(rsp_tid_changed), .rsp_version_out(rsp_version_out),
      .rsp_version_crc(rsp_version_crc), .rsp_type_bitmap(rsp_type_bitmap),
      .rsp_cmd_bits_low(rsp_cmd_bits_low), .rsp_cmd_bits_high(rsp_cmd_bits_high)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reflected crc-32 over the word, bit 0 first
   function automatic logic [31:0] crc32_word(input logic [31:0] w);
      logic [31:0] c;
      logic        fb;
      c = CRC_INIT;
      for (int i = 0; i < 32; i++) begin
         fb = c[0] ^ w[i];
         c = c >> 1;
         if (fb) c = c ^ CRC_POLY;
      end
      return ~c;
   endfunction

   function automatic bit lookup_version(input logic [7:0] ptype, output logic [31:0] ver);
      ver = version_regs[REG_VERSION_TYPE0];
      case (ptype)
         TYPE_BASE:     return 1'b1;
         TYPE_PLATFORM: ver = version_regs[REG_VERSION_TYPE2];
         TYPE_FRU:      ver = version_regs[REG_VERSION_TYPE4];
         TYPE_FW:       ver = version_regs[REG_VERSION_TYPE5];
         TYPE_RDE:      ver = version_regs[REG_VERSION_TYPE6];
         default:       return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic op_type classify(input logic [7:0] cmd);
      case (cmd)
         CMD_SET_TID:   return OP_SET_TID;
         CMD_GET_TID:   return OP_GET_TID;
         CMD_GET_VER:   return OP_GET_VER;
         CMD_GET_TYPES: return OP_GET_TYPES;
         CMD_GET_CMDS:  return OP_GET_CMDS;
         default:       return OP_UNSUP;
      endcase
   endfunction

   // works out the response and updates the stored terminus id
   function automatic rsp_type predict_response(input pldm_request_type rq);
      rsp_type     r;
      logic [31:0] ver;
      bit          known;
      r = '0;
      r.completion_code = CC_OK;
      case (classify(rq.cmd))
         OP_SET_TID: begin
            if (rq.tid == TID_UNASSIGNED || rq.tid == TID_RESERVED) begin
               r.completion_code = CC_INVALID_DATA;
            end else begin
               stored_tid = rq.tid;
               r.tid_changed = 1'b1;
            end
         end
         OP_GET_TID: r.tid_out = stored_tid;
         OP_GET_VER: begin
            known = lookup_version(rq.ptype, ver);
            if (rq.xfer != XFER_FIRST) r.completion_code = CC_BAD_XFER;
            if (!known) r.completion_code = CC_BAD_TYPE;
            r.version_out = ver;
            r.version_crc = crc32_word(ver);
         end
         OP_GET_TYPES: r.type_bitmap = TYPES_BITMAP;
         OP_GET_CMDS: begin
            known = lookup_version(rq.ptype, ver);
            if (!known) begin
               r.completion_code = CC_BAD_TYPE;
            end else if (rq.version != ver) begin
               r.completion_code = CC_BAD_VERSION;
            end else begin
               case (rq.ptype)
                  TYPE_BASE: r.cmd_bits_low = CMDS_BASE_LO;
                  TYPE_PLATFORM: begin
                     r.cmd_bits_low = CMDS_PLATFORM_LO;
                     r.cmd_bits_high = CMDS_PLATFORM_HI;
                  end
                  TYPE_FRU: r.cmd_bits_low = CMDS_FRU_LO;
                  TYPE_FW:  r.cmd_bits_low = CMDS_FW_LO;
                  default:  r.cmd_bits_low = CMDS_RDE_LO;
               endcase
            end
         end
         default: r.completion_code = CC_UNSUPPORTED;
      endcase
      return r;
   endfunction

   function automatic pldm_request_type make_request(input logic [7:0] cmd,
                                                     input logic [7:0] tid,
                                                     input logic [7:0] xfer,
                                                     input logic [7:0] ptype,
                                                     input logic [31:0] version);
      pldm_request_type rq;
      rq.cmd = cmd;
      rq.tid = tid;
      rq.xfer = xfer;
      rq.ptype = ptype;
      rq.version = version;
      return rq;
   endfunction

   function automatic logic [7:0] pick_type(input int known_pct);
      logic [7:0] known_types [5];
      known_types = '{TYPE_BASE, TYPE_PLATFORM, TYPE_FRU, TYPE_FW, TYPE_RDE};
      if ($urandom_range(99) < known_pct) return known_types[$urandom_range(4)];
      return 8'($urandom_range(255));
   endfunction

   // mostly well-formed requests with random payload, some noise
   function automatic pldm_request_type random_request();
      pldm_request_type rq;
      int               pick;
      logic [31:0]      ver;
      rq = make_request(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)), $urandom());
      pick = $urandom_range(99);
      if (pick < 15) begin
         rq.cmd = CMD_SET_TID;
         if ($urandom_range(9) == 0) rq.tid = $urandom_range(1) ? TID_RESERVED : TID_UNASSIGNED;
      end else if (pick < 25) begin
         rq.cmd = CMD_GET_TID;
      end else if (pick < 50) begin
         rq.cmd = CMD_GET_VER;
         if ($urandom_range(99) < 70) rq.xfer = XFER_FIRST;
         rq.ptype = pick_type(75);
      end else if (pick < 55) begin
         rq.cmd = CMD_GET_TYPES;
      end else if (pick < 85) begin
         rq.cmd = CMD_GET_CMDS;
         rq.ptype = pick_type(75);
         void'(lookup_version(rq.ptype, ver));
         if ($urandom_range(99) < 70) rq.version = ver;
      end else if (pick < 88) begin
         rq.cmd = CMD_NONE;
      end else begin
         rq.cmd = 8'($urandom_range(255, CMD_GET_CMDS + 1));
      end
      return rq;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch on item %0d: %s got %h expected %h",
               $realtime, n_checked, what, got, want);
      fail_count++;
   endtask

   task automatic send_request(input pldm_request_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_cmd <= rq.cmd;
      req_tid <= rq.tid;
      req_transfer_op <= rq.xfer;
      req_pldm_type <= rq.ptype;
      req_version <= rq.version;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_rsps.push_back(predict_response(rq));
      op_count[classify(rq.cmd)]++;
      n_sent++;
   endtask

   task automatic wait_for_responses();
      push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input reg_idx_type idx, input logic [31:0] data,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // writes all five version registers and reads each one back
   task automatic program_versions(input logic [31:0] v0, input logic [31:0] v2,
                                   input logic [31:0] v4, input logic [31:0] v5,
                                   input logic [31:0] v6);
      logic [31:0] vals [5];
      logic [31:0] rdata;
      reg_idx_type idx;
      vals = '{v0, v2, v4, v5, v6};
      for (int i = 0; i < 5; i++) begin
         idx = reg_idx_type'(i);
         csr_access(1'b1, idx, vals[i], rdata);
         version_regs[idx] = vals[i];
         csr_access(1'b0, idx, '0, rdata);
         if (rdata !== vals[i])
            report_mismatch("register readback", 64'(rdata), 64'(vals[i]));
      end
      n_settings++;
   endtask

   task automatic check_response();
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch("response with none pending", 64'(rsp_completion_code), '0);
         return;
      end
      want = expected_rsps.pop_front();
      n_checked++;
      if (rsp_completion_code !== want.completion_code)
         report_mismatch("completion_code", 64'(rsp_completion_code),
                         64'(want.completion_code));
      if (rsp_tid_out !== want.tid_out)
         report_mismatch("tid_out", 64'(rsp_tid_out), 64'(want.tid_out));
      if (rsp_tid_changed !== want.tid_changed)
         report_mismatch("tid_changed", 64'(rsp_tid_changed), 64'(want.tid_changed));
      if (rsp_version_out !== want.version_out)
         report_mismatch("version_out", 64'(rsp_version_out), 64'(want.version_out));
      if (rsp_version_crc !== want.version_crc)
         report_mismatch("version_crc", 64'(rsp_version_crc), 64'(want.version_crc));
      if (rsp_type_bitmap !== want.type_bitmap)
         report_mismatch("type_bitmap", 64'(rsp_type_bitmap), 64'(want.type_bitmap));
      if (rsp_cmd_bits_low !== want.cmd_bits_low)
         report_mismatch("cmd_bits_low", rsp_cmd_bits_low, want.cmd_bits_low);
      if (rsp_cmd_bits_high !== want.cmd_bits_high)
         report_mismatch("cmd_bits_high", 64'(rsp_cmd_bits_high), 64'(want.cmd_bits_high));
   endtask

   // response side: checks each popped item, random stalls and long hold-offs
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) check_response();
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                  stall_cycles, expected_rsps.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_reset_values();
      send_request(make_request(CMD_GET_TID, 8'h00, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_GET_VER, 8'h00, XFER_FIRST, TYPE_BASE, '0));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, TYPE_BASE, '0));
      wait_for_responses();
   endtask

   task automatic test_directed();
      program_versions(32'hFFFF_FFFF, 32'h0000_0000, 32'h0102_0304, 32'h8000_0000,
                       32'hF1F0_F000);
      send_idle_pct = 23;
      recv_idle_pct = 85;
      send_request(make_request(CMD_SET_TID, TID_UNASSIGNED, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_SET_TID, TID_RESERVED, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_GET_TID, 8'hFF, 8'hFF, 8'hFF, '1));
      send_request(make_request(CMD_SET_TID, 8'h01, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_SET_TID, 8'hFE, 8'hFF, 8'hFF, '1));
      send_request(make_request(CMD_SET_TID, 8'hFE, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_GET_TID, 8'h00, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_GET_VER, 8'h00, XFER_FIRST, TYPE_BASE, '0));
      send_request(make_request(CMD_GET_VER, 8'h00, XFER_FIRST, TYPE_PLATFORM, '0));
      send_request(make_request(CMD_GET_VER, 8'h00, XFER_FIRST, TYPE_FRU, '0));
      send_request(make_request(CMD_GET_VER, 8'h00, XFER_FIRST, TYPE_FW, '0));
      send_request(make_request(CMD_GET_VER, 8'h00, XFER_FIRST, TYPE_RDE, '0));
      // bad transfer flag still returns the version
      send_request(make_request(CMD_GET_VER, 8'h00, 8'h00, TYPE_FRU, '0));
      // bad type wins over bad transfer flag
      send_request(make_request(CMD_GET_VER, 8'h00, 8'hFF, 8'hFF, '1));
      send_request(make_request(CMD_GET_VER, 8'h00, XFER_FIRST, 8'h01, '0));
      send_request(make_request(CMD_GET_TYPES, 8'h00, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, TYPE_BASE, 32'hFFFF_FFFF));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, TYPE_PLATFORM, 32'h0));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, TYPE_FRU, 32'h0102_0304));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, TYPE_FW, 32'h8000_0000));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, TYPE_RDE, 32'hF1F0_F000));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, TYPE_FW, 32'h7FFF_FFFF));
      send_request(make_request(CMD_GET_CMDS, 8'h00, 8'h00, 8'h03, 32'h0));
      send_request(make_request(CMD_NONE, 8'hFF, 8'hFF, 8'hFF, '1));
      send_request(make_request(CMD_LAST, 8'h00, 8'h00, 8'h00, '0));
      send_request(make_request(CMD_GET_CMDS + 8'h01, 8'h00, 8'h00, 8'h00, '0));
      wait_for_responses();
   endtask

   task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n) send_request(random_request());
      wait_for_responses();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = HOLD_CYCLES;
      repeat (60) send_request(random_request());
      wait_for_responses();
   endtask

   task automatic test_drain_pause();
      send_idle_pct = 0;
      recv_idle_pct = 50;
      repeat (20) send_request(random_request());
      wait_for_responses();
      repeat (20) send_request(random_request());
      wait_for_responses();
   endtask

   initial begin
      foreach (version_regs[i]) version_regs[i] = '0;
      foreach (op_count[i]) op_count[i] = 0;
      stored_tid = TID_UNASSIGNED;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      program_versions($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      test_random_traffic(PHASE_ITEMS, 23, 85);
      program_versions('1, '1, '1, '1, '1);
      test_random_traffic(PHASE_ITEMS, 85, 23);
      program_versions($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      test_random_traffic(PHASE_ITEMS, 0, 0);
      test_backpressure();
      test_drain_pause();
      repeat (20) @(posedge clock);
      $display("covered %0d requests: set tid %0d, get tid %0d, get version %0d, ",
               n_sent, op_count[OP_SET_TID], op_count[OP_GET_TID], op_count[OP_GET_VER]);
      $display("get types %0d, get commands %0d, unsupported %0d; %0d checked, %0d settings",
               op_count[OP_GET_TYPES], op_count[OP_GET_CMDS], op_count[OP_UNSUP],
               n_checked, n_settings);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
sv/pcr_pkg.sv
sv/pcr_fifo.sv
sv/pcr_csr.sv
sv/pcr_front.sv
sv/pcr_back.sv
sv/pldm_control_responder.sv
bench/tb.sv
